// ----- hw/rtl/asl_pkg.sv -----
// Shared types and constants for the address to symbol lookup block.
// No dependencies; the lookup top, the cell and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package asl_pkg;

    localparam int ADDR_W  = 32;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int CFG_IDX_W = 1;

    // func field codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC_COUNT = 1'b1;

    // entry write, broadcast to every cell
    typedef struct packed {
        logic               we;
        logic               bank;
        logic [INDEX_W-1:0] index;
        logic [ADDR_W-1:0]  start;
        logic [ADDR_W-1:0]  span;
        logic [ADDR_W-1:0]  name;
    } load_t;

    // lookup context, held steady while a scan runs
    typedef struct packed {
        logic               bank;
        logic               nearest;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
    } query_t;

    // partial result handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              have_best;
        logic [ADDR_W-1:0] best;
        logic [ADDR_W-1:0] name;
    } scan_t;

endpackage

`default_nettype wire

// ----- hw/rtl/asl_in_if.sv -----
// Request channel of the symbol lookup block: valid/ready plus item fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface asl_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        bank;
    logic [7:0]  entry_index;
    logic [31:0] entry_start;
    logic [31:0] entry_span;
    logic [31:0] entry_name;
    logic [31:0] query_address;
    logic        allow_nearest;

    modport source (
        output valid, func, bank, entry_index, entry_start, entry_span,
               entry_name, query_address, allow_nearest,
        input  ready
    );

    modport sink (
        input  valid, func, bank, entry_index, entry_start, entry_span,
               entry_name, query_address, allow_nearest,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/asl_out_if.sv -----
// Result channel of the symbol lookup block: valid/ready plus result fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface asl_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic        exact_hit;
    logic [31:0] name_offset;

    modport source (
        output valid, found, exact_hit, name_offset,
        input  ready
    );

    modport sink (
        input  valid, found, exact_hit, name_offset,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/address_to_symbol_lookup_top.sv -----
// Address to symbol lookup: request decode, count registers, result buffer
// and the row of symbol cells. Depends on asl_pkg, asl_in_if, asl_out_if, asl_cell.
//
//   port      dir   handshake         carries
//   req       in    valid/ready       load or lookup beat (all item fields)
//   rsp       out   valid/ready       found, exact_hit, name_offset
//   cfg_*     in    cfg_we only       static_count / dynamic_count writes
//
// A load beat is written into its cell at the edge that accepts it; req
// stays ready while no lookup is in flight, so loads then stream at one per cycle.
// A lookup beat launches a scan token down ENTRIES cells, one cell per
// cycle: with the output register free the result goes through launch_reg,
// every cell's scan register and the output register, whatever the count;
// req.ready stays low until the result is loaded into the output register.
// Reset clears counts, the scan token and the result buffer; the entry
// storage keeps no reset and is valid only once loaded.
// A stalled rsp holds req only while a finished result waits in the holding
// register behind a full output register; it moves up as rsp drains.
`timescale 1ns / 1ps
`default_nettype none

module address_to_symbol_lookup_top #(
    parameter int unsigned ENTRIES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    asl_in_if.sink           req,
    asl_out_if.source        rsp,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);
    import asl_pkg::*;

    // ---- configuration registers ----
    logic [COUNT_W-1:0] static_count_reg;
    logic [COUNT_W-1:0] dynamic_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            static_count_reg  <= '0;
            dynamic_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STATIC_COUNT:  static_count_reg  <= cfg_data;
                CFG_DYNAMIC_COUNT: dynamic_count_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ---- request decode ----
    logic   busy_reg;
    logic   busy_next;
    logic   req_fire;
    logic   lookup_fire;
    load_t  load;
    query_t query_reg;
    logic   launch_reg;

    assign req.ready   = !busy_reg;
    assign req_fire    = req.valid && !busy_reg;
    assign lookup_fire = req_fire && (req.func == FUNC_LOOKUP);

    // load beats go straight into the addressed cell
    always_comb
    begin
        load.we    = req_fire && (req.func == FUNC_LOAD);
        load.bank  = req.bank;
        load.index = req.entry_index;
        load.start = req.entry_start;
        load.span  = req.entry_span;
        load.name  = req.entry_name;
    end

    // lookup context stays put for the whole scan
    always_ff @(posedge clk)
    begin
        if (lookup_fire)
        begin
            query_reg.bank    <= req.bank;
            query_reg.nearest <= req.allow_nearest;
            query_reg.addr    <= req.query_address;
            query_reg.count   <= req.bank ? dynamic_count_reg : static_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= lookup_fire;
        end
    end

    // ---- cell row ----
    // Counts above ENTRIES need no clamp: every cell is then active.
    scan_t chain [0:ENTRIES];

    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = launch_reg;
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        asl_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (load),
            .query    (query_reg),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1])
        );
    end

    // ---- result buffer ----
    scan_t tail;
    logic  res_found;

    assign tail      = chain[ENTRIES];
    assign res_found = tail.hit || tail.have_best;   // have_best only with nearest

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_found_reg;
    logic              out_exact_reg;
    logic [ADDR_W-1:0] out_name_reg;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic              pend_found_reg;
    logic              pend_exact_reg;
    logic [ADDR_W-1:0] pend_name_reg;
    logic              out_free;
    logic              out_load_tail;
    logic              out_load_pend;
    logic              pend_load;

    assign out_free      = !out_valid_reg || rsp.ready;
    assign out_load_tail = tail.valid && out_free;
    assign pend_load     = tail.valid && !out_free;
    assign out_load_pend = !tail.valid && pend_valid_reg && out_free;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        busy_next       = busy_reg;

        if (out_load_tail || out_load_pend)
        begin
            out_valid_next = 1'b1;
            busy_next      = 1'b0;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pend_load)
        begin
            pend_valid_next = 1'b1;
        end
        else if (out_load_pend)
        begin
            pend_valid_next = 1'b0;
        end

        if (lookup_fire)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_tail)
        begin
            out_found_reg <= res_found;
            out_exact_reg <= tail.hit;
            out_name_reg  <= tail.name;
        end
        else if (out_load_pend)
        begin
            out_found_reg <= pend_found_reg;
            out_exact_reg <= pend_exact_reg;
            out_name_reg  <= pend_name_reg;
        end

        if (pend_load)
        begin
            pend_found_reg <= res_found;
            pend_exact_reg <= tail.hit;
            pend_name_reg  <= tail.name;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.exact_hit   = out_exact_reg;
    assign rsp.name_offset = out_name_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/asl_cell.sv -----
// One symbol cell: holds entry CELL_INDEX of both banks and folds it into
// the scan beat passing by. Depends on asl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asl_cell #(
    parameter int unsigned CELL_INDEX = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire asl_pkg::load_t  load,
    input  wire asl_pkg::query_t query,
    input  wire asl_pkg::scan_t  scan_in,
    output asl_pkg::scan_t       scan_out
);
    import asl_pkg::*;

    localparam logic [ADDR_W-1:0] CELL_ID = ADDR_W'(CELL_INDEX);

    logic [ADDR_W-1:0] start_reg [0:1];
    logic [ADDR_W-1:0] span_reg  [0:1];
    logic [ADDR_W-1:0] name_reg  [0:1];

    scan_t scan_reg;
    scan_t scan_next;

    logic [ADDR_W-1:0] ent_start;
    logic [ADDR_W-1:0] ent_end;
    logic [ADDR_W-1:0] ent_name;
    logic              active;
    logic              in_range;
    logic              closer;

    // entry storage, undefined until loaded
    always_ff @(posedge clk)
    begin
        if (load.we && ({{(ADDR_W-INDEX_W){1'b0}}, load.index} == CELL_ID))
        begin
            start_reg[load.bank] <= load.start;
            span_reg[load.bank]  <= load.span;
            name_reg[load.bank]  <= load.name;
        end
    end

    always_comb
    begin
        ent_start = start_reg[query.bank];
        ent_name  = name_reg[query.bank];
        ent_end   = ent_start + span_reg[query.bank];   // wraps mod 2^32
        active    = {{(ADDR_W-COUNT_W){1'b0}}, query.count} > CELL_ID;
        in_range  = (query.addr >= ent_start) && (query.addr < ent_end);
        closer    = query.nearest && (ent_start > scan_in.best)
                    && (ent_start <= query.addr);

        scan_next = scan_in;
        if (scan_in.valid && !scan_in.hit && active)
        begin
            if (in_range)
            begin
                scan_next.hit  = 1'b1;
                scan_next.name = ent_name;
            end
            else if (closer)
            begin
                scan_next.have_best = 1'b1;
                scan_next.best      = ent_start;
                scan_next.name      = ent_name;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for address_to_symbol_lookup_top: table loads,
// exact and nearest-below lookups and count register settings, checked beat by beat.
// Depends on asl_pkg, asl_in_if, asl_out_if and the lookup RTL.
`timescale 1ns / 1ps

module tb;
    import asl_pkg::*;

    localparam int ENTRIES         = 256;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int MAX_GAP         = 12;
    localparam int LONG_STALL_MAX  = 600;
    // Longest quiet stretch of a good run: a full scan, a long rsp stall,
    // the settle time before a register write and a sender gap.
    localparam int IDLE_LIMIT = 4 * (2 * ENTRIES + 8 + MAX_GAP + LONG_STALL_MAX);

    // One request beat as it sits on the req channel.
    typedef struct packed {
        logic        func;
        logic        bank;
        logic [7:0]  entry_index;
        logic [31:0] entry_start;
        logic [31:0] entry_span;
        logic [31:0] entry_name;
        logic [31:0] query_address;
        logic        allow_nearest;
    } req_beat_t;

    // One result beat as the rsp channel should carry it.
    typedef struct packed {
        logic        found;
        logic        exact_hit;
        logic [31:0] name_offset;
    } lookup_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and every DUT input start at a known value at time 0.
    // ------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    req_beat_t  req_beat  = '0;
    logic       rsp_ready = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [0:0] cfg_index = CFG_STATIC_COUNT;
    logic [8:0] cfg_data  = '0;

    asl_in_if  req_if ();
    asl_out_if rsp_if ();

    assign req_if.valid         = req_valid;
    assign req_if.func          = req_beat.func;
    assign req_if.bank          = req_beat.bank;
    assign req_if.entry_index   = req_beat.entry_index;
    assign req_if.entry_start   = req_beat.entry_start;
    assign req_if.entry_span    = req_beat.entry_span;
    assign req_if.entry_name    = req_beat.entry_name;
    assign req_if.query_address = req_beat.query_address;
    assign req_if.allow_nearest = req_beat.allow_nearest;
    assign rsp_if.ready         = rsp_ready;

    address_to_symbol_lookup_top #(.ENTRIES(ENTRIES)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the symbol table and count registers.
    // sym_loaded marks entries that a load has written; lookups are only
    // ever issued with a count that covers loaded entries.
    // ------------------------------------------------------------------
    logic [31:0] sym_start  [2][ENTRIES];
    logic [31:0] sym_span   [2][ENTRIES];
    logic [31:0] sym_name   [2][ENTRIES];
    logic        sym_loaded [2][ENTRIES];
    logic [8:0]  static_cnt  = '0;
    logic [8:0]  dynamic_cnt = '0;

    req_beat_t      pending_beats [$];
    lookup_result_t expected_lookups [$];

    int   mismatch_count = 0;
    int   idle_cycles    = 0;
    logic req_fire       = 1'b0;

    // Sender burst/gap state and receiver stall state.
    int burst_left = 1;
    int gap_left   = 0;
    int stall_left = 0;
    int calm_left  = 0;

    // Scan in index order: first range hit wins; otherwise, with nearest set,
    // the lowest index with the greatest nonzero start not above the address.
    // The range end wraps at 2^32 like the 32-bit sum it is.
    function automatic lookup_result_t resolve_address(input logic bank,
                                                       input logic [31:0] addr,
                                                       input logic nearest);
        int unsigned    cnt;
        int             i;
        logic [31:0]    s;
        logic [31:0]    range_end;
        logic [31:0]    best;
        logic [31:0]    best_name;
        logic           have_best;
        lookup_result_t r;
        cnt       = 32'(bank ? dynamic_cnt : static_cnt);
        if (cnt > ENTRIES)
            cnt = ENTRIES;
        best      = '0;
        best_name = '0;
        have_best = 1'b0;
        r         = '0;
        for (i = 0; i < cnt; i++)
        begin
            s         = sym_start[bank][i];
            range_end = s + sym_span[bank][i];
            if (addr >= s && addr < range_end)
            begin
                r.found       = 1'b1;
                r.exact_hit   = 1'b1;
                r.name_offset = sym_name[bank][i];
                return r;
            end
            if (nearest && s > best && s <= addr)
            begin
                best      = s;
                best_name = sym_name[bank][i];
                have_best = 1'b1;
            end
        end
        if (nearest && have_best)
        begin
            r.found       = 1'b1;
            r.name_offset = best_name;
        end
        return r;
    endfunction

    function automatic int loaded_prefix(input logic bank);
        int n;
        n = 0;
        while (n < ENTRIES && sym_loaded[bank][n])
            n++;
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge. Accepted loads update the shadow
    // table, accepted lookups queue their expected result, accepted results
    // are checked against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        lookup_result_t want;
        if (!rst_n)
        begin
            req_fire    <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            req_fire <= req_valid && req_if.ready;
            if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (req_valid && req_if.ready)
            begin
                if (req_if.func == FUNC_LOAD)
                begin
                    if (req_if.entry_index < ENTRIES)
                    begin
                        sym_start[req_if.bank][req_if.entry_index]  = req_if.entry_start;
                        sym_span[req_if.bank][req_if.entry_index]   = req_if.entry_span;
                        sym_name[req_if.bank][req_if.entry_index]   = req_if.entry_name;
                        sym_loaded[req_if.bank][req_if.entry_index] = 1'b1;
                    end
                end
                else
                    expected_lookups.push_back(resolve_address(req_if.bank,
                                                               req_if.query_address,
                                                               req_if.allow_nearest));
            end

            if (rsp_if.valid && rsp_ready)
            begin
                if (expected_lookups.size() == 0)
                    report_mismatch("result beat with none pending", rsp_if.name_offset, '0);
                else
                begin
                    want = expected_lookups.pop_front();
                    if (rsp_if.found !== want.found)
                        report_mismatch("found", 32'(rsp_if.found), 32'(want.found));
                    if (rsp_if.exact_hit !== want.exact_hit)
                        report_mismatch("exact_hit", 32'(rsp_if.exact_hit),
                                        32'(want.exact_hit));
                    if (rsp_if.name_offset !== want.name_offset)
                        report_mismatch("name_offset", rsp_if.name_offset, want.name_offset);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: change req at the falling edge. A beat stays up until the
    // monitor saw it taken; between beats the sender runs bursts of random
    // length separated by random gaps (sometimes none).
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        req_beat_t next_beat;
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!(req_valid && !req_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_beats.size() == 0)
                req_valid <= 1'b0;
            else
            begin
                next_beat = pending_beats.pop_front();
                req_beat  <= next_beat;
                req_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
                end
            end
        end
    end

    // Receiver: mostly ready, short stalls, calm stretches with no stall,
    // and now and then a long stall that backs results up into the block.
    always @(negedge clk)
    begin : receiver
        int pick;
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            rsp_ready <= 1'b1;
        end
        else
        begin
            pick = $urandom_range(0, 999);
            if (pick < 600)
                rsp_ready <= 1'b1;
            else if (pick < 850)
            begin
                stall_left = $urandom_range(0, 7);
                rsp_ready  <= 1'b0;
            end
            else if (pick < 990)
            begin
                calm_left = $urandom_range(20, 300);
                rsp_ready <= 1'b1;
            end
            else
            begin
                stall_left = $urandom_range(100, LONG_STALL_MAX);
                rsp_ready  <= 1'b0;
            end
        end
    end

    // Watchdog: too long without any accepted beat ends the run.
    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Fields a beat does not use still get random bits.
    // ------------------------------------------------------------------
    task automatic push_load(input logic bank, input logic [7:0] idx,
                             input logic [31:0] s, input logic [31:0] sp,
                             input logic [31:0] nm);
        req_beat_t b;
        b.func          = FUNC_LOAD;
        b.bank          = bank;
        b.entry_index   = idx;
        b.entry_start   = s;
        b.entry_span    = sp;
        b.entry_name    = nm;
        b.query_address = $urandom();
        b.allow_nearest = 1'($urandom_range(0, 1));
        pending_beats.push_back(b);
    endtask

    task automatic push_lookup(input logic bank, input logic [31:0] addr,
                               input logic nearest);
        req_beat_t b;
        b.func          = FUNC_LOOKUP;
        b.bank          = bank;
        b.entry_index   = 8'($urandom_range(0, 255));
        b.entry_start   = $urandom();
        b.entry_span    = $urandom();
        b.entry_name    = $urandom();
        b.query_address = addr;
        b.allow_nearest = nearest;
        pending_beats.push_back(b);
    endtask

    // Block idle: nothing queued, nothing on req, no result outstanding,
    // then a further wait so a trailing load has surely landed.
    task automatic settle_block();
        while (pending_beats.size() != 0 || req_valid || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 4) @(posedge clk);
    endtask

    task automatic write_counts(input logic [8:0] s_cnt, input logic [8:0] d_cnt);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STATIC_COUNT;
        cfg_data  <= s_cnt;
        @(negedge clk);
        cfg_index <= CFG_DYNAMIC_COUNT;
        cfg_data  <= d_cnt;
        @(negedge clk);
        cfg_we <= 1'b0;
        static_cnt  = s_cnt;
        dynamic_cnt = d_cnt;
    endtask

    // Starts cluster in a small window so ranges overlap and nearest-below
    // has competition; a few are zero, near the top, or anywhere.
    function automatic logic [31:0] random_start();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return $urandom();
            2:       return 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: return 32'h4000_0000 | $urandom_range(0, 32'h3FFF);
        endcase
    endfunction

    function automatic logic [31:0] random_span();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return $urandom();
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 32'h200);
        endcase
    endfunction

    // Addresses aimed at range edges of loaded entries, plus noise.
    function automatic logic [31:0] random_query(input logic bank);
        int          n;
        int          j;
        logic [31:0] s;
        logic [31:0] sp;
        n = loaded_prefix(bank);
        if (n == 0)
            return $urandom();
        j  = $urandom_range(0, n - 1);
        s  = sym_start[bank][j];
        sp = sym_span[bank][j];
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return 32'h4000_0000 | $urandom_range(0, 32'h3FFF);
            2:       return s;
            3:       return s + sp - 1;
            4:       return s + sp;
            5:       return s - 1;
            default: return s + $urandom_range(0, 32'h100);
        endcase
    endfunction

    // Counts never reach past the loaded prefix; above ENTRIES only when
    // the whole bank is loaded (the block then makes every cell active).
    function automatic logic [8:0] pick_count(input int p);
        case ($urandom_range(0, 5))
            0:       return 9'd0;
            1:       return (p > 0) ? 9'd1 : 9'd0;
            2:       return 9'($urandom_range(0, p));
            3:       return (p == ENTRIES) ? 9'($urandom_range(ENTRIES + 1, 511)) : 9'(p);
            default: return 9'(p);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence: reset, directed corner cases, random phases, wrap-up.
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int   ph;
        int   pushed;
        int   act;
        int   fill_pct;
        int   run_len;
        int   fill_ptr [2];
        logic b;
        logic [8:0] s_cnt;
        logic [8:0] d_cnt;

        for (int k = 0; k < ENTRIES; k++)
        begin
            sym_loaded[0][k] = 1'b0;
            sym_loaded[1][k] = 1'b0;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Counts are zero after reset: nothing can be found.
        push_lookup(1'b0, 32'h0000_0000, 1'b1);
        push_lookup(1'b1, 32'hFFFF_FFFF, 1'b1);

        // Static bank: zero start, range wrapping past 2^32, zero span with a
        // duplicate start, and an overlap that the lower index must win.
        push_load(1'b0, 8'd0, 32'h0000_0000, 32'h0000_0010, 32'hA000_0000);
        push_load(1'b0, 8'd1, 32'hFFFF_FFF0, 32'h0000_0020, 32'h0000_00A1);
        push_load(1'b0, 8'd2, 32'h0000_1000, 32'h0000_0100, 32'h0000_00A2);
        push_load(1'b0, 8'd3, 32'h0000_1000, 32'h0000_0000, 32'h0000_00A3);
        push_load(1'b0, 8'd4, 32'h0000_0800, 32'h0000_1000, 32'h0000_00A4);
        // Dynamic bank: top address with a span that wraps to zero, a range
        // ending one short of the top, and the last index at all ones.
        push_load(1'b1, 8'd0, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        push_load(1'b1, 8'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555);
        push_load(1'b1, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);

        settle_block();
        write_counts(9'd5, 9'd2);

        push_lookup(1'b0, 32'h0000_0005, 1'b0);   // exact hit on a zero start
        push_lookup(1'b0, 32'h0000_1050, 1'b0);   // overlap, lower index first
        push_lookup(1'b0, 32'h0000_0900, 1'b1);
        push_lookup(1'b0, 32'h0000_2000, 1'b1);   // nearest, tie on start
        push_lookup(1'b0, 32'h0000_2000, 1'b0);   // miss without fallback
        push_lookup(1'b0, 32'hFFFF_FFFF, 1'b1);   // wrapped range: nearest only
        push_lookup(1'b0, 32'hFFFF_FFF8, 1'b0);
        push_lookup(1'b1, 32'hFFFF_FFFE, 1'b0);
        push_lookup(1'b1, 32'hFFFF_FFFF, 1'b1);   // end is exclusive
        push_lookup(1'b1, 32'h7FFF_FFFF, 1'b1);   // nothing at or below

        // Random phases. Each waits for an idle block (so the sender pauses
        // until every result is in), sets both counts, then queues a mix of
        // table-fill runs, stray loads and lookups.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle_block();
            fill_ptr[0] = loaded_prefix(1'b0);
            fill_ptr[1] = loaded_prefix(1'b1);
            if (ph == NUM_PHASES - 1)
            begin
                s_cnt = (fill_ptr[0] == ENTRIES) ? 9'd511 : 9'(fill_ptr[0]);
                d_cnt = 9'(fill_ptr[1]);
            end
            else
            begin
                s_cnt = pick_count(fill_ptr[0]);
                d_cnt = pick_count(fill_ptr[1]);
            end
            write_counts(s_cnt, d_cnt);

            pushed = 0;
            while (pushed < ITEMS_PER_PHASE)
            begin
                fill_pct = (fill_ptr[0] < ENTRIES || fill_ptr[1] < ENTRIES) ? 55 : 0;
                act      = $urandom_range(0, 99);
                if (act < fill_pct)
                begin
                    // grow one bank's loaded prefix by a short run
                    if (fill_ptr[0] == ENTRIES)
                        b = 1'b1;
                    else if (fill_ptr[1] == ENTRIES)
                        b = 1'b0;
                    else
                        b = 1'($urandom_range(0, 1));
                    run_len = $urandom_range(1, 8);
                    while (run_len > 0 && fill_ptr[b] < ENTRIES)
                    begin
                        push_load(b, fill_ptr[b][7:0], random_start(), random_span(),
                                  $urandom());
                        fill_ptr[b]++;
                        run_len--;
                        pushed++;
                    end
                end
                else if (act < fill_pct + 12)
                begin
                    // overwrite anywhere, in use or not
                    push_load(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              random_start(), random_span(), $urandom());
                    pushed++;
                end
                else
                begin
                    b = 1'($urandom_range(0, 1));
                    push_lookup(b, random_query(b), $urandom_range(0, 3) != 0);
                    pushed++;
                end
            end
        end

        settle_block();
        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
